// ----- design/iira_pkg.sv -----
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types and constants for the indexed insert/remove array: request and
// result payloads, request kinds, controller states, and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package iira_pkg;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_REMOVE = 2'd3
    } req_kind_t;

    // capacity loaded at reset, before any configuration write
    localparam logic [6:0] CAP_RESET = 7'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  position;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [6:0]  element_count;
        logic [6:0]  logical_capacity;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GROW,
        ST_FILL,
        ST_SH_RD,
        ST_SH_WR,
        ST_RM_RD,
        ST_RM_WR,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic rd_capture;
        logic grow_step;
        logic ptr_from_cnt;
        logic ptr_from_idx;
        logic fill_write;
        logic sh_read;
        logic sh_write;
        logic rm_read;
        logic rm_write;
        logic rm_done;
    } cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      in_range;
        logic      fits;
        logic      cap_short;
        logic      at_gap;
        logic      sh_more;
        logic      rm_more;
    } sts_t;

endpackage

// ----- design/iira_ram.sv -----
// ----------------------------------------------------------------------------
// iira_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module iira_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/iira_ctrl.sv -----
// ----------------------------------------------------------------------------
// iira_ctrl
// Request sequencer: decodes the request, steps capacity growth, and walks the
// gap fill and element shifts one memory access per cycle.
// ----------------------------------------------------------------------------
module iira_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  iira_pkg::sts_t sts,
    output iira_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);

    import iira_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    REQ_READ:   state_next = sts.in_range ? ST_RD_WAIT : ST_FINISH;
                    REQ_REMOVE: state_next = sts.in_range ? ST_RM_RD : ST_FINISH;
                    default:    state_next = sts.fits ? ST_GROW : ST_FINISH;
                endcase
            end
            ST_GROW:
            begin
                if (!sts.cap_short)
                begin
                    state_next = sts.in_range ? ST_SH_RD : ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!sts.at_gap)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SH_RD:   state_next = ST_SH_WR;
            ST_SH_WR:   state_next = sts.sh_more ? ST_SH_RD : ST_FILL;
            ST_RM_RD:   state_next = sts.rm_more ? ST_RM_WR : ST_FINISH;
            ST_RM_WR:   state_next = ST_RM_RD;
            ST_RD_WAIT: state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    REQ_READ:   cmd.rd_issue     = sts.in_range;
                    REQ_REMOVE: cmd.ptr_from_idx = sts.in_range;
                    default:    cmd              = '0;
                endcase
            end
            ST_GROW:
            begin
                cmd.grow_step    = sts.cap_short;
                cmd.ptr_from_cnt = !sts.cap_short;
            end
            ST_FILL:    cmd.fill_write = 1'b1;
            ST_SH_RD:   cmd.sh_read    = 1'b1;
            ST_SH_WR:   cmd.sh_write   = 1'b1;
            ST_RM_RD:
            begin
                cmd.rm_read = sts.rm_more;
                cmd.rm_done = !sts.rm_more;
            end
            ST_RM_WR:   cmd.rm_write   = 1'b1;
            ST_RD_WAIT: cmd.rd_capture = 1'b1;
            ST_FINISH:  done           = 1'b1;
            default:    cmd            = '0;
        endcase
    end

endmodule

// ----- design/iira_dp.sv -----
// ----------------------------------------------------------------------------
// iira_dp
// Array datapath: request registers, element count, logical capacity, the walk
// pointer and the element memory, driven by the controller's commands.
// ----------------------------------------------------------------------------
module iira_dp #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  iira_pkg::req_t req,
    input  logic           cfg_we,
    input  logic [6:0]     cfg_wdata,
    input  iira_pkg::cmd_t cmd,
    output iira_pkg::sts_t sts,
    output iira_pkg::rsp_t result
);

    import iira_pkg::*;

    // wide enough for a position, for DEPTH and for one past DEPTH
    localparam int CW = ($clog2(DEPTH + 2) > 7) ? $clog2(DEPTH + 2) : 7;
    localparam int AW = $clog2(DEPTH);

    req_kind_t             kind_reg;
    logic [CW-1:0]         idx_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cap_reg;
    logic [CW-1:0]         ptr_reg;
    logic                  ok_reg;
    logic [31:0]           rdv_reg;

    logic [CW-1:0]         cnt_next;
    logic [CW-1:0]         cap_next;
    logic [CW-1:0]         ptr_next;

    logic [CW-1:0]         need;
    logic [CW-1:0]         ptr_dec;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         cfg_ext;
    logic [CW-1:0]         cap_cfg;
    logic [CW-1:0]         cap_rst;
    logic [CW-1:0]         cap_grown;
    logic [63:0]           val_wide;
    logic [63:0]           rd_wide;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign need    = ((idx_reg > cnt_reg) ? idx_reg : cnt_reg) + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);
    assign ptr_inc = ptr_reg + CW'(1);
    assign cfg_ext = CW'(cfg_wdata);
    assign cap_cfg = (cfg_ext > CW'(DEPTH)) ? CW'(DEPTH) : cfg_ext;
    assign cap_rst = (CW'(CAP_RESET) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(CAP_RESET);
    // double plus one below half depth, else saturate
    assign cap_grown = (cap_reg < CW'(DEPTH / 2)) ? CW'(cap_reg * 2 + 1) : CW'(DEPTH);
    assign val_wide  = 64'(req.item_value);
    assign rd_wide   = 64'(ram_rdata);

    assign sts.kind      = kind_reg;
    assign sts.in_range  = idx_reg < cnt_reg;
    assign sts.fits      = need <= CW'(DEPTH);
    assign sts.cap_short = cap_reg < need;
    assign sts.at_gap    = ptr_reg < idx_reg;
    assign sts.sh_more   = ptr_reg > (idx_reg + CW'(1));
    assign sts.rm_more   = ptr_reg < cnt_reg;

    // memory port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[AW-1:0];
        if (cmd.fill_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = sts.at_gap ? '0 : val_reg;
        end
        if (cmd.sh_write)
        begin
            ram_we = 1'b1;
        end
        if (cmd.rm_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = ptr_dec[AW-1:0];
        end
        if (cmd.rd_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = idx_reg[AW-1:0];
        end
        if (cmd.sh_read)
        begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec[AW-1:0];
        end
        if (cmd.rm_read)
        begin
            ram_re = 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        cap_next = cap_reg;
        ptr_next = ptr_reg;
        if (cfg_we)
        begin
            cnt_next = '0;
            cap_next = cap_cfg;
        end
        if (cmd.grow_step)
        begin
            cap_next = cap_grown;
        end
        if (cmd.ptr_from_cnt)
        begin
            ptr_next = cnt_reg;
        end
        if (cmd.ptr_from_idx)
        begin
            ptr_next = idx_reg + CW'(1);
        end
        if (cmd.fill_write)
        begin
            if (sts.at_gap)
            begin
                ptr_next = ptr_inc;
            end
            else
            begin
                cnt_next = need;
            end
        end
        if (cmd.sh_write)
        begin
            ptr_next = ptr_dec;
        end
        if (cmd.rm_write)
        begin
            ptr_next = ptr_inc;
        end
        if (cmd.rm_done)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            cap_reg <= cap_rst;
            ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            cap_reg <= cap_next;
            ptr_reg <= ptr_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_kind_t'(req.req_type);
            idx_reg  <= (req_kind_t'(req.req_type) == REQ_APPEND) ? cnt_reg
                                                                  : CW'(req.position);
            val_reg  <= val_wide[DATA_WIDTH-1:0];
            ok_reg   <= 1'b0;
            rdv_reg  <= '0;
        end
        if (cmd.rd_capture)
        begin
            ok_reg  <= 1'b1;
            rdv_reg <= rd_wide[31:0];
        end
        if ((cmd.fill_write && !sts.at_gap) || cmd.rm_done)
        begin
            ok_reg <= 1'b1;
        end
    end

    assign result.ok               = ok_reg;
    assign result.read_value       = rdv_reg;
    assign result.element_count    = cnt_reg[6:0];
    assign result.logical_capacity = cap_reg[6:0];

    iira_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- design/indexed_insert_remove_array_top.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_top
// Ordered word array with read, insert-at-index, append and remove-at-index.
//
// Usage: present a request on req and raise start; the transfer happens at a
// rising edge with start high and busy low. One result follows on result,
// marked by done for exactly one cycle; the receiver cannot stall it.
// Writing cfg_wdata with cfg_we empties the array and reloads the logical
// capacity (clamped to DEPTH); write it only while busy is low.
// Steps, start to done: a read issues the memory read and captures the word;
// a remove reads each later element and writes it one place down; an insert
// or append grows the capacity step by step, shifts later elements one place
// up (each a read, then a write), clears any gap entries below the index and
// writes the item. An out-of-range read or remove, or an insert or append
// that would overflow DEPTH, goes straight to done with ok low.
// One request is in flight at a time; the next may start the cycle after
// done. Reset empties the array and sets capacity to min(10, DEPTH); no
// memory clearing pass is needed, as only entries below the count are read.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array_top #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  iira_pkg::req_t req,
    input  logic           cfg_we,
    input  logic [6:0]     cfg_wdata,
    output logic           done,
    output iira_pkg::rsp_t result
);

    import iira_pkg::*;

    cmd_t cmd;
    sts_t sts;

    iira_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    iira_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after result");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.read_value == '0))
        else $error("failed request returned nonzero read value");

    a_cap_covers: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((DEPTH > 127) || (result.logical_capacity >= result.element_count)))
        else $error("element count exceeds logical capacity");
`endif

endmodule
